// File: design/polynomial_evaluator_core_assert.svh
// ----------------------------------------------------------------------------
// polynomial evaluator assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVALUATOR_CORE_ASSERT_SVH
`define POLYNOMIAL_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/polyeval_pkg.sv
// ----------------------------------------------------------------------------
// polyeval_pkg
// Shared widths, register indexes, state and control types of the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package polyeval_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned DEGREE_W   = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register map
  localparam int unsigned CFG_DEGREE    = 0;
  localparam int unsigned CFG_COEF_BASE = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic round;
    logic add;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: design/polynomial_evaluator_core.sv
// ----------------------------------------------------------------------------
// polynomial_evaluator_core
// Fixed-point calibration polynomial, Horner scheme over a coefficient ring.
// ----------------------------------------------------------------------------
// Pulse start with a Q16.16 sample while busy is low; the block evaluates
// coef_0 + coef_1*x + ... + coef_d*x^d, d being the degree register clamped to
// MAX_DEGREE, and shows the saturated Q32.16 value with its overflow flag on
// value_o/overflow_o for exactly one cycle under done_o. The receiver cannot
// hold the result off, so it must sample it in that cycle. busy stays high
// from the accepted sample through the done cycle; busy is low in the cycle
// after done, and the next sample is taken at the earliest at the edge that
// ends that idle cycle. Each Horner step uses the single 24 x 32 bit
// multiplier twice, followed by a rounding step and an add step; the
// coefficient ring turns once all the way round per sample and walks
// past unused high coefficients one per cycle. Registers: index 0 is the
// degree, index k+1 is coef_k; write them only while busy is low.
`default_nettype none
`include "polynomial_evaluator_core_assert.svh"

module polynomial_evaluator_core import polyeval_pkg::*; #(
  parameter  int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter  int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned CFG_IDX_W  = $clog2(MAX_DEGREE + 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       done_o,
  output logic signed [ACC_W-1:0]    value_o,
  output logic                       overflow_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned NUM_CELLS = MAX_DEGREE + 1;
  localparam int unsigned ROT_W     = $clog2(NUM_CELLS);

  state_e                     state_q, state_d;
  logic [ROT_W-1:0]           rot_q, rot_d;
  logic [DEGREE_W-1:0]        degree_q, degree_d;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [ROT_W-1:0]         deg_eff;
  logic [ROT_W-1:0]         cur_k;
  logic                     last;
  logic                     at_top;
  logic                     accept;
  logic                     shift;
  logic                     rot_inc;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic                     ovf;

  logic signed [COEF_W-1:0] coef_row [NUM_CELLS];

  // coefficient ring: cell k takes from cell k-1, head is the last cell
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic signed [COEF_W-1:0] prev;
    logic                     wr_en;

    assign prev  = (k == 0) ? coef_row[NUM_CELLS-1] : coef_row[(k == 0) ? 0 : k-1];
    assign wr_en = cfg_we_i && (cfg_idx_i == CFG_IDX_W'(CFG_COEF_BASE + k));

    polyeval_coef_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .wr_en_i   (wr_en),
      .wr_data_i (cfg_data_i[COEF_W-1:0]),
      .prev_i    (prev),
      .coef_o    (coef_row[k])
    );
  end

  polyeval_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_q),
    .coef_i   (coef_row[NUM_CELLS-1]),
    .acc_o    (acc),
    .ovf_o    (ovf)
  );

  always_comb begin
    deg_eff = (32'(degree_q) > MAX_DEGREE) ? ROT_W'(MAX_DEGREE) : ROT_W'(degree_q);
    // coefficient index now at the head of the ring
    cur_k   = ROT_W'(MAX_DEGREE) - rot_q;
    last    = (rot_q == ROT_W'(MAX_DEGREE));
    at_top  = (cur_k == deg_eff);
    accept  = start && (state_q == ST_IDLE);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (at_top) state_d = last ? ST_DONE : ST_MUL_LO;
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_ACC;
      ST_ACC:    state_d = last ? ST_DONE : ST_MUL_LO;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mac_ctrl = '0;
    shift    = 1'b0;
    case (state_q)
      ST_WALK: begin
        shift         = 1'b1;
        mac_ctrl.load = at_top;
      end
      ST_MUL_LO: mac_ctrl.mul_lo = 1'b1;
      ST_MUL_HI: mac_ctrl.mul_hi = 1'b1;
      ST_ROUND:  mac_ctrl.round  = 1'b1;
      ST_ACC: begin
        shift        = 1'b1;
        mac_ctrl.add = 1'b1;
      end
      default: begin
        shift    = 1'b0;
        mac_ctrl = '0;
      end
    endcase
    // the final turn brings the ring home without moving the counter
    rot_inc = shift && !last;
    busy    = (state_q != ST_IDLE);
    done_o  = (state_q == ST_DONE);
  end

  always_comb begin
    rot_d = rot_q;
    if (accept) begin
      rot_d = '0;
    end else if (rot_inc) begin
      rot_d = rot_q + 1'b1;
    end
    degree_d = degree_q;
    if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(CFG_DEGREE))) begin
      degree_d = cfg_data_i[DEGREE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rot_q    <= '0;
      degree_q <= '0;
    end else begin
      state_q  <= state_d;
      rot_q    <= rot_d;
      degree_q <= degree_d;
    end
  end

  // sample beat is held for the whole evaluation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

  assign value_o    = acc;
  assign overflow_o = ovf;

  `PE_ASSERT_IMPL(a_done_busy, done_o, busy, "result strobe outside an evaluation")
  `PE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
  `PE_ASSERT_NEXT(a_done_idle, done_o, !busy, "sequencer did not return to idle")
  `PE_ASSERT_IMPL(a_ring_home, done_o, rot_q == ROT_W'(MAX_DEGREE), "ring not back home")
  `PE_ASSERT_NEXT(a_sample_hold, busy, $stable(sample_q), "sample changed during work")

endmodule

`default_nettype wire

// File: design/polyeval_coef_cell.sv
// ----------------------------------------------------------------------------
// polyeval_coef_cell
// One coefficient slot of the ring; writable in place, passes its value on.
// ----------------------------------------------------------------------------
`default_nettype none

module polyeval_coef_cell import polyeval_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic                     wr_en_i,
  input  logic signed [COEF_W-1:0] wr_data_i,
  input  logic signed [COEF_W-1:0] prev_i,
  output logic signed [COEF_W-1:0] coef_o
);

  logic signed [COEF_W-1:0] coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (shift_i) begin
      coef_d = prev_i;
    end else if (wr_en_i) begin
      coef_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// File: design/polyeval_mac.sv
// ----------------------------------------------------------------------------
// polyeval_mac
// Shared Horner step: acc * x rounded to nearest, then + coef, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module polyeval_mac import polyeval_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  output logic signed [ACC_W-1:0]    acc_o,
  output logic                       ovf_o
);

  localparam int unsigned SPLIT_W   = ACC_W / 2;
  localparam int unsigned LO_PROD_W = SPLIT_W + SAMPLE_W;
  localparam int unsigned PROD_W    = ACC_W + SAMPLE_W;

  localparam logic [PROD_W-1:0] HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] POS_LIM =
    {{(PROD_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic [PROD_W-1:0] NEG_LIM =
    {{(PROD_W-ACC_W){1'b0}}, 1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic [LO_PROD_W-1:0]    plo_q, plo_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic signed [ACC_W-1:0] pr_q, pr_d;

  logic [ACC_W-1:0]     acc_mag;
  logic [SAMPLE_W-1:0]  smp_mag;
  logic                 neg;
  logic [SPLIT_W-1:0]   mul_a;
  logic [LO_PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]    rnd;
  logic [PROD_W-1:0]    mag;
  logic                 rnd_ovf;
  logic [ACC_W:0]       sum;
  logic                 sum_ovf;

  always_comb begin
    acc_mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
    smp_mag = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
    neg     = acc_q[ACC_W-1] ^ sample_i[SAMPLE_W-1];
    // one 24 x 32 multiplier, low half of the magnitude first
    mul_a   = ctrl_i.mul_hi ? acc_mag[ACC_W-1:SPLIT_W] : acc_mag[SPLIT_W-1:0];
    mul_p   = {{SAMPLE_W{1'b0}}, mul_a} * {{SPLIT_W{1'b0}}, smp_mag};
    // rounding on the magnitude gives ties away from zero
    rnd     = prod_q + HALF;
    mag     = rnd >> FRAC_BITS;
    rnd_ovf = neg ? (mag > NEG_LIM) : (mag > POS_LIM);
    sum     = {pr_q[ACC_W-1], pr_q}
            + {{(ACC_W+1-COEF_W){coef_i[COEF_W-1]}}, coef_i};
    sum_ovf = sum[ACC_W] ^ sum[ACC_W-1];
  end

  always_comb begin
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    plo_d  = plo_q;
    prod_d = prod_q;
    pr_d   = pr_q;
    if (ctrl_i.load) begin
      acc_d = {{(ACC_W-COEF_W){coef_i[COEF_W-1]}}, coef_i};
      ovf_d = 1'b0;
    end
    if (ctrl_i.mul_lo) begin
      plo_d = mul_p;
    end
    if (ctrl_i.mul_hi) begin
      prod_d = ({{(PROD_W-LO_PROD_W){1'b0}}, mul_p} << SPLIT_W)
             + {{(PROD_W-LO_PROD_W){1'b0}}, plo_q};
    end
    if (ctrl_i.round) begin
      if (rnd_ovf) begin
        pr_d  = neg ? ACC_MIN : ACC_MAX;
        ovf_d = 1'b1;
      end else if (neg) begin
        pr_d = ~mag[ACC_W-1:0] + 1'b1;
      end else begin
        pr_d = mag[ACC_W-1:0];
      end
    end
    if (ctrl_i.add) begin
      if (sum_ovf) begin
        acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        ovf_d = 1'b1;
      end else begin
        acc_d = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
    plo_q  <= plo_d;
    prod_q <= prod_d;
    pr_q   <= pr_d;
  end

  assign acc_o = acc_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire
